// ===== hw/rtl/aabb_pkg.sv =====
// Shared types, constants and widths for the swept box collision resolver.
// No dependencies; imported by every module in hw/rtl.
package aabb_pkg;
  localparam int CoordW = 32;
  localparam int SizeW = 24;
  localparam int NumW = 35;
  localparam int DenW = 33;
  localparam int QuotFracBitsDef = 16;

  typedef enum logic [2:0] {
    SIDE_NONE  = 3'd0,
    SIDE_UP    = 3'd1,
    SIDE_DOWN  = 3'd2,
    SIDE_LEFT  = 3'd3,
    SIDE_RIGHT = 3'd4
  } side_t;

  typedef struct packed {
    logic inf;
    logic zero;
  } ratio_flags_t;
endpackage

// ===== hw/rtl/aabb_collision_resolver.sv =====
// Swept box collision resolver top level: overlap test, four ratio dividers, side pick.
// Throughput one request per cycle while the output is not stalled.
// Depth is set by the chain of divide cells, one quotient bit per cell.
// The whole pipeline advances together; stall on the output freezes it.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// Depends on aabb_pkg, aabb_ratio_div, aabb_div_cell.
module aabb_collision_resolver import aabb_pkg::*; #(
  parameter int QUOT_FRAC_BITS = QuotFracBitsDef
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CoordW-1:0] dyn_x,
  input  logic signed [CoordW-1:0] dyn_y,
  input  logic signed [CoordW-1:0] last_x,
  input  logic signed [CoordW-1:0] last_y,
  input  logic [SizeW-1:0]         dyn_width,
  input  logic [SizeW-1:0]         dyn_height,
  input  logic signed [CoordW-1:0] box_x,
  input  logic signed [CoordW-1:0] box_y,
  input  logic [SizeW-1:0]         box_width,
  input  logic [SizeW-1:0]         box_height,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CoordW-1:0] new_x,
  output logic signed [CoordW-1:0] new_y,
  output logic [2:0]               side
);
  localparam int QW = NumW + QUOT_FRAC_BITS;
  localparam int EW = 34;

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: edges, overlap, numerators, motion
  logic               s1_v, s1_ov;
  logic signed [EW-1:0] s1_dx, s1_dy, s1_up_e, s1_dn_e, s1_rt_e, s1_lf_e;
  logic signed [NumW-1:0] s1_nu, s1_nd, s1_nr, s1_nl;
  logic signed [DenW-1:0] s1_vx, s1_vy;

  logic signed [EW-1:0] e_dx, e_dy, e_lx, e_ly, e_bx, e_by, e_up, e_dn, e_rt, e_lf;
  always_comb begin
    e_dx = EW'(dyn_x);
    e_dy = EW'(dyn_y);
    e_lx = EW'(last_x);
    e_ly = EW'(last_y);
    e_bx = EW'(box_x);
    e_by = EW'(box_y);
    e_up = e_by + $signed({10'b0, box_height});
    e_dn = e_by - $signed({10'b0, dyn_height});
    e_rt = e_bx + $signed({10'b0, box_width});
    e_lf = e_bx - $signed({10'b0, dyn_width});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
    end
    if (adv) begin
      s1_ov <= (e_dx < e_rt) && (e_dx + $signed({10'b0, dyn_width}) > e_bx) &&
               (e_dy < e_up) && (e_dy + $signed({10'b0, dyn_height}) > e_by);
      s1_dx <= e_dx;
      s1_dy <= e_dy;
      s1_up_e <= e_up;
      s1_dn_e <= e_dn;
      s1_rt_e <= e_rt;
      s1_lf_e <= e_lf;
      s1_nu <= NumW'(e_up - e_ly);
      s1_nd <= NumW'(e_dn - e_ly);
      s1_nr <= NumW'(e_rt - e_lx);
      s1_nl <= NumW'(e_lf - e_lx);
      s1_vx <= DenW'(e_dx - e_lx);
      s1_vy <= DenW'(e_dy - e_ly);
    end
  end

  // stage 2: magnitudes and signs for the dividers
  logic [QW-1:0] mag_n [4];
  logic [DenW-1:0] mag_d [4];
  logic [3:0] neg_s, den_z;
  logic signed [NumW-1:0] nums [4];
  logic signed [DenW-1:0] dens [4];
  always_comb begin
    nums[0] = s1_nu; nums[1] = s1_nd; nums[2] = s1_nr; nums[3] = s1_nl;
    dens[0] = s1_vy; dens[1] = s1_vy; dens[2] = s1_vx; dens[3] = s1_vx;
    for (int k = 0; k < 4; k++) begin
      mag_n[k] = {(nums[k][NumW-1] ? NumW'(-nums[k]) : nums[k]),
                  {QUOT_FRAC_BITS{1'b0}}};
      mag_d[k] = dens[k][DenW-1] ? DenW'(-dens[k]) : dens[k];
      neg_s[k] = nums[k][NumW-1] ^ dens[k][DenW-1];
      den_z[k] = (dens[k] == '0);
    end
  end

  logic [QW-1:0] quot [4];
  for (genvar k = 0; k < 4; k++) begin : g_div
    aabb_ratio_div #(.QW(QW), .DW(DenW)) u_div (
      .clk(clk), .adv(adv), .num(mag_n[k]), .den(mag_d[k]), .quot(quot[k])
    );
  end

  // side-band delay line alongside the divider cells
  typedef struct packed {
    logic                 v;
    logic                 ov;
    logic [3:0]           neg;
    logic [3:0]           dz;
    logic signed [EW-1:0] dx, dy, up_e, dn_e, rt_e, lf_e;
  } band_t;

  band_t band [QW+1];
  assign band[0] = '{v: s1_v, ov: s1_ov, neg: neg_s, dz: den_z, dx: s1_dx, dy: s1_dy,
                     up_e: s1_up_e, dn_e: s1_dn_e, rt_e: s1_rt_e, lf_e: s1_lf_e};
  for (genvar i = 0; i < QW; i++) begin : g_band
    always_ff @(posedge clk) begin
      if (rst) begin
        band[i+1].v <= 1'b0;
      end else if (adv) begin
        band[i+1].v <= band[i].v;
      end
      if (adv) begin
        band[i+1].ov <= band[i].ov;
        band[i+1].neg <= band[i].neg;
        band[i+1].dz <= band[i].dz;
        band[i+1].dx <= band[i].dx;
        band[i+1].dy <= band[i].dy;
        band[i+1].up_e <= band[i].up_e;
        band[i+1].dn_e <= band[i].dn_e;
        band[i+1].rt_e <= band[i].rt_e;
        band[i+1].lf_e <= band[i].lf_e;
      end
    end
  end

  // final stage: classify, pick side, snap, saturate
  band_t b;
  ratio_flags_t fl [4];
  logic [3:0] w;
  logic [2:0] sd;
  logic signed [EW-1:0] nx, ny;
  assign b = band[QW];

  function automatic logic lt(input ratio_flags_t fa, input logic [QW-1:0] qa,
                              input ratio_flags_t fb, input logic [QW-1:0] qb);
    logic res;
    if (fa.inf) res = 1'b0;
    else if (fb.inf) res = 1'b1;
    else res = qa < qb;
    return res;
  endfunction

  function automatic logic signed [CoordW-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > EW'(34'sh07FFFFFFF)) r = 32'sh7FFFFFFF;
    else if (v < -EW'(34'sh080000000)) r = 32'sh80000000;
    else r = CoordW'(v);
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fl[k].zero = !b.dz[k] && (quot[k] == '0);
      fl[k].inf = b.dz[k] || (b.neg[k] && (quot[k] != '0));
    end
    // index 0 up, 1 down, 2 right, 3 left
    w = (fl[0].zero ? 4'd4 : 4'd0) + (fl[3].zero ? 4'd4 : 4'd0) +
        (fl[2].zero ? 4'd3 : 4'd0) + (fl[1].zero ? 4'd2 : 4'd0);
    sd = SIDE_NONE;
    nx = b.dx;
    ny = b.dy;
    if (b.ov) begin
      if (w > 4'd6) sd = SIDE_UP;
      else if (w == 4'd6) sd = SIDE_LEFT;
      else if (w == 4'd5) sd = SIDE_RIGHT;
      else if (lt(fl[3], quot[3], fl[1], quot[1]) && lt(fl[3], quot[3], fl[2], quot[2]) &&
               lt(fl[3], quot[3], fl[0], quot[0])) sd = SIDE_LEFT;
      else if (lt(fl[2], quot[2], fl[1], quot[1]) && lt(fl[2], quot[2], fl[0], quot[0]) &&
               lt(fl[2], quot[2], fl[3], quot[3])) sd = SIDE_RIGHT;
      else if (lt(fl[0], quot[0], fl[1], quot[1]) && lt(fl[0], quot[0], fl[2], quot[2]) &&
               lt(fl[0], quot[0], fl[3], quot[3])) sd = SIDE_UP;
      else sd = SIDE_DOWN;
      unique case (sd)
        SIDE_UP:   ny = b.up_e;
        SIDE_DOWN: ny = b.dn_e;
        SIDE_LEFT: nx = b.lf_e;
        default:   nx = b.rt_e;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= b.v;
    end
    if (adv) begin
      new_x <= sat(nx);
      new_y <= sat(ny);
      side <= sd;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_x) && $stable(new_y) && $stable(side))
    else $error("result changed under stall");
  assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output stall");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> side <= 3'(SIDE_RIGHT))
    else $error("side code out of range");
endmodule

// ===== hw/rtl/aabb_div_cell.sv =====
// One restoring-division step cell of the pipelined ratio divider.
// Depends on aabb_pkg.
module aabb_div_cell import aabb_pkg::*; #(
  parameter int QW = NumW + QuotFracBitsDef,
  parameter int DW = DenW
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [QW-1:0] num_in,
  input  logic [DW:0]   rem_in,
  input  logic [DW-1:0] den_in,
  output logic [QW-1:0] num_out,
  output logic [DW:0]   rem_out,
  output logic [DW-1:0] den_out
);
  logic [DW+1:0] shifted;
  logic [DW+1:0] diff;

  always_comb begin
    shifted = {rem_in, num_in[QW-1]};
    diff = shifted - {2'b00, den_in};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_out <= den_in;
      if (!diff[DW+1]) begin
        rem_out <= diff[DW:0];
        num_out <= {num_in[QW-2:0], 1'b1};
      end else begin
        rem_out <= shifted[DW:0];
        num_out <= {num_in[QW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== hw/rtl/aabb_ratio_div.sv =====
// Pipelined unsigned divider made of a chain of step cells, one quotient bit per cell.
// Depends on aabb_pkg and aabb_div_cell.
module aabb_ratio_div import aabb_pkg::*; #(
  parameter int QW = NumW + QuotFracBitsDef,
  parameter int DW = DenW
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [QW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot
);
  logic [QW-1:0] n_chain [QW+1];
  logic [DW:0]   r_chain [QW+1];
  logic [DW-1:0] d_chain [QW+1];

  assign n_chain[0] = num;
  assign r_chain[0] = '0;
  assign d_chain[0] = den;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    aabb_div_cell #(.QW(QW), .DW(DW)) u_cell (
      .clk(clk), .adv(adv),
      .num_in(n_chain[i]), .rem_in(r_chain[i]), .den_in(d_chain[i]),
      .num_out(n_chain[i+1]), .rem_out(r_chain[i+1]), .den_out(d_chain[i+1])
    );
  end

  assign quot = n_chain[QW];
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the swept box collision resolver: directed cases, then random requests.
// Holds its own model of the side pick and snapping, and compares every result with it.
// Depends on aabb_pkg and aabb_collision_resolver.
module testbench;
  import aabb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = QuotFracBitsDef;
  localparam int Latency = FracBits + 36;

  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    side_t              sd;
  } resolve_t;

  typedef struct {
    logic signed [31:0] dx, dy, lx, ly, bx, by;
    logic [23:0]        dw, dh, bw, bh;
  } boxes_t;

  typedef struct {
    bit          inf;
    bit          zero;
    longint      q;
  } ratio_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] dyn_x = '0, dyn_y = '0, last_x = '0, last_y = '0;
  logic signed [31:0] box_x = '0, box_y = '0;
  logic [23:0] dyn_width = '0, dyn_height = '0, box_width = '0, box_height = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] new_x, new_y;
  logic [2:0] side;

  resolve_t pending[$];
  int errors = 0;
  int requests = 0;
  int results = 0;
  int side_hits[5];
  bit stall_random = 1'b1;

  aabb_collision_resolver u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .dyn_x(dyn_x), .dyn_y(dyn_y), .last_x(last_x), .last_y(last_y),
    .dyn_width(dyn_width), .dyn_height(dyn_height), .box_x(box_x), .box_y(box_y),
    .box_width(box_width), .box_height(box_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_x(new_x), .new_y(new_y), .side(side)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic ratio_t entry_ratio(longint num, longint den);
    ratio_t r;
    r.inf = 1'b0;
    r.zero = 1'b0;
    r.q = 0;
    if (den == 0) begin
      r.inf = 1'b1;
    end else begin
      r.q = (num * (longint'(1) << FracBits)) / den;
      if (r.q == 0) r.zero = 1'b1;
      else if (r.q < 0) r.inf = 1'b1;
    end
    return r;
  endfunction

  function automatic bit earlier(ratio_t a, ratio_t b);
    if (a.inf) return 1'b0;
    if (b.inf) return 1'b1;
    return a.q < b.q;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic resolve_t resolve(boxes_t b);
    resolve_t r;
    longint dx, dy, lx, ly, bx, by, dw, dh, bw, bh, nx, ny;
    ratio_t up, dn, rt, lf;
    int w;
    dx = b.dx; dy = b.dy; lx = b.lx; ly = b.ly; bx = b.bx; by = b.by;
    dw = b.dw; dh = b.dh; bw = b.bw; bh = b.bh;
    nx = dx;
    ny = dy;
    r.sd = SIDE_NONE;
    if (dx < bx + bw && dx + dw > bx && dy < by + bh && dy + dh > by) begin
      up = entry_ratio(by + bh - ly, dy - ly);
      dn = entry_ratio(by - dh - ly, dy - ly);
      rt = entry_ratio(bx + bw - lx, dx - lx);
      lf = entry_ratio(bx - dw - lx, dx - lx);
      w = (up.zero ? 4 : 0) + (lf.zero ? 4 : 0) + (rt.zero ? 3 : 0) + (dn.zero ? 2 : 0);
      if (w > 6) r.sd = SIDE_UP;
      else if (w == 6) r.sd = SIDE_LEFT;
      else if (w == 5) r.sd = SIDE_RIGHT;
      else if (earlier(lf, dn) && earlier(lf, rt) && earlier(lf, up)) r.sd = SIDE_LEFT;
      else if (earlier(rt, dn) && earlier(rt, up) && earlier(rt, lf)) r.sd = SIDE_RIGHT;
      else if (earlier(up, dn) && earlier(up, rt) && earlier(up, lf)) r.sd = SIDE_UP;
      else r.sd = SIDE_DOWN;
      case (r.sd)
        SIDE_UP:   ny = by + bh;
        SIDE_DOWN: ny = by - dh;
        SIDE_LEFT: nx = bx - dw;
        default:   nx = bx + bw;
      endcase
    end
    r.nx = clamp32(nx);
    r.ny = clamp32(ny);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_request(boxes_t b);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    dyn_x <= b.dx; dyn_y <= b.dy; last_x <= b.lx; last_y <= b.ly;
    dyn_width <= b.dw; dyn_height <= b.dh; box_x <= b.bx; box_y <= b.by;
    box_width <= b.bw; box_height <= b.bh;
    do @(posedge clk); while (in_stall);
    pending = {pending, resolve(b)};
    requests++;
  endtask

  always @(posedge clk) begin
    resolve_t e;
    if (!rst && out_valid && !out_stall) begin
      results++;
      if (pending.size() == 0) begin
        errors++;
        $display("unexpected result at %0t", $realtime);
      end else begin
        e = pending.pop_front();
        if (side <= 4) side_hits[side]++;
        if (new_x !== e.nx) report("new_x", new_x, e.nx);
        if (new_y !== e.ny) report("new_y", new_y, e.ny);
        if (side !== e.sd) report("side", side, e.sd);
      end
    end
  end

  always @(posedge clk) begin
    int p;
    p = $urandom_range(0, 99);
    if (!stall_random) out_stall <= 1'b0;
    else if (out_stall) out_stall <= (p < 70) && ($urandom_range(0, 19) != 0);
    else out_stall <= (p < 25);
  end

  function automatic logic signed [31:0] rand_coord();
    return $urandom();
  endfunction

  function automatic boxes_t rand_boxes(bit near);
    boxes_t b;
    int s;
    s = $urandom_range(0, 9);
    if (!near) begin
      b.dx = $urandom(); b.dy = $urandom(); b.lx = $urandom(); b.ly = $urandom();
      b.bx = $urandom(); b.by = $urandom();
      b.dw = 24'($urandom()); b.dh = 24'($urandom());
      b.bw = 24'($urandom()); b.bh = 24'($urandom());
      return b;
    end
    b.bx = rand_coord() >>> $urandom_range(0, 8);
    b.by = rand_coord() >>> $urandom_range(0, 8);
    b.bw = (s == 0) ? 24'($urandom()) : 24'($urandom_range(1, 4096));
    b.bh = (s == 1) ? 24'($urandom()) : 24'($urandom_range(1, 4096));
    b.dw = (s == 2) ? 24'($urandom()) : 24'($urandom_range(1, 4096));
    b.dh = (s == 3) ? 24'($urandom()) : 24'($urandom_range(1, 4096));
    b.dx = b.bx + $signed($urandom_range(0, 8000)) - $signed(b.dw) + 1;
    b.dy = b.by + $signed($urandom_range(0, 8000)) - $signed(b.dh) + 1;
    case ($urandom_range(0, 4))
      0: begin b.lx = b.dx; b.ly = b.dy - $signed($urandom_range(0, 3000)); end
      1: begin b.lx = b.bx - $signed(b.dw); b.ly = b.dy + $signed($urandom_range(0, 300)); end
      2: begin b.lx = b.bx + $signed(b.bw); b.ly = b.by + $signed(b.bh); end
      3: begin b.lx = b.dx; b.ly = b.dy; end
      default: begin
        b.lx = b.dx - $signed($urandom_range(0, 6000)) + 3000;
        b.ly = b.dy - $signed($urandom_range(0, 6000)) + 3000;
      end
    endcase
    return b;
  endfunction

  task automatic wait_drained();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending.size() != 0 && guard < 100000);
  endtask

  task automatic test_directed();
    boxes_t b;
    b = '{dx: 100, dy: 100, lx: 100, ly: 100, bx: 0, by: 0, dw: 256, dh: 256, bw: 512, bh: 512};
    send_request(b);  // no motion: all infinite, default down
    b.ly = 1000; send_request(b);  // falling onto top
    b.ly = -1000; send_request(b);
    b.ly = 100; b.lx = -1000; send_request(b);
    b.lx = 1000; send_request(b);
    b.lx = -256; b.ly = 512; send_request(b);  // exact zeros on left and up
    b.lx = 512; b.ly = -256; send_request(b);  // zeros on right and down
    b.lx = 512; b.ly = 100; send_request(b);
    b.lx = 100; b.ly = -256; send_request(b);
    b.lx = 100; b.ly = 512; send_request(b);
    b.lx = -256; b.ly = 100; send_request(b);
    b.dx = 2000; send_request(b);  // no overlap
    b = '{dx: 32'sh7fffff00, dy: 32'sh7fffff00, lx: 32'sh80000000, ly: 32'sh80000000,
          bx: 32'sh7ffff000, by: 32'sh7ffff000, dw: 24'hffffff, dh: 24'hffffff,
          bw: 24'hffffff, bh: 24'hffffff};
    send_request(b);  // box near the positive extreme; left and down tie, so it snaps down
    b = '{dx: 32'sh80000000, dy: 32'sh80000000, lx: 32'sh7fffffff, ly: 32'sh7fffffff,
          bx: 32'sh80000010, by: 32'sh80000010, dw: 24'hffffff, dh: 24'hffffff,
          bw: 24'hffffff, bh: 24'hffffff};
    send_request(b);  // snaps past the negative extreme
    b.dw = 0; send_request(b);  // zero width, no overlap here
    b = '{dx: -1, dy: -1, lx: 0, ly: 0, bx: -1, by: -1, dw: 1, dh: 1, bw: 1, bh: 1};
    send_request(b);
    b = '{dx: 0, dy: 0, lx: 0, ly: 0, bx: 0, by: 0, dw: 0, dh: 0, bw: 0, bh: 0};
    send_request(b);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 150) stall_random = 1'b0;
      if (i % 300 == 250) stall_random = 1'b1;
      send_request(rand_boxes($urandom_range(0, 99) < 85));
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_request(rand_boxes(1'b1));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random(1500);
    test_drain_pause();
    wait_drained();
    repeat (Latency + 10) @(posedge clk);
    $display("covered %0d requests, %0d results", requests, results);
    $display("sides none/up/down/left/right: %0d/%0d/%0d/%0d/%0d",
             side_hits[0], side_hits[1], side_hits[2], side_hits[3], side_hits[4]);
    if (errors == 0 && pending.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending.size());
    $display("testbench failed");
    $finish;
  end
endmodule
